// ===== hdl/otdq_pkg.sv =====
// Package for the ordered task dispatch queue: payload structs, codes and the
// command and status types between controller and datapath. No dependencies.
`timescale 1ns / 1ps
package otdq_pkg;

  typedef enum logic [2:0] {
    ACT_SUBMIT   = 3'd0,
    ACT_CANCEL   = 3'd1,
    ACT_DISPATCH = 3'd2,
    ACT_COMPLETE = 3'd3,
    ACT_START    = 3'd4,
    ACT_STOP     = 3'd5,
    ACT_PAUSE    = 3'd6,
    ACT_RESUME   = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_NOT_RUNNING   = 3'd1,
    ST_UNSCHEDULABLE = 3'd2,
    ST_FULL          = 3'd3,
    ST_NOT_FOUND     = 3'd4,
    ST_AT_LIMIT      = 3'd5,
    ST_EMPTY         = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_PAUSED  = 2'd2
  } mode_e;

  localparam logic [1:0] POLICY_PRIORITY = 2'd0;
  localparam logic [1:0] POLICY_SHORTEST = 2'd2;
  localparam logic       CFG_POLICY      = 1'b0;
  localparam logic       CFG_MAX_RUN     = 1'b1;
  localparam logic [7:0] MAX_RUN_RESET   = 8'd10;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] task_tag;
    logic [7:0]  task_priority;
    logic [23:0] job_size;
    logic        can_schedule;
    logic [31:0] target_id;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_id;
    logic [15:0] result_tag;
    logic [4:0]  queue_level;
    logic [7:0]  running_count;
    logic [1:0]  run_mode;
    logic [31:0] scheduled_total;
    logic [31:0] completed_total;
  } out_beat_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // capture the input beat and search the queue
    logic execute;  // apply the captured beat
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic done;
  } dp_status_t;

endpackage

// ===== hdl/ordered_task_dispatch_queue.sv =====
// Top level of the ordered task dispatch queue: joins controller and datapath.
// Depends on otdq_pkg, otdq_ctrl and otdq_dp.
`timescale 1ns / 1ps
// Each input beat is one scheduler action and yields exactly one result beat.
// An action is a load step and an execute step: in the load step the queue is compared against the
// incoming beat in every slot at once (insert position for a submit, id match
// for a cancel) and the flags are registered; in the execute step the sorted
// shift queue moves one place on an insert or removal and the counters and run
// state update. One action is in flight at a time, so a new beat is not taken
// until the previous action has executed. A stalled result holds the action in
// its execute step until the output side drains.
module ordered_task_dispatch_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  otdq_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output otdq_pkg::out_beat_t out_data_o
);
  import otdq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t sts;

  otdq_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  otdq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i(in_data_i), .out_o(out_data_o), .cmd_i(cmd), .sts_o(sts)
  );
endmodule

// ===== hdl/otdq_ctrl.sv =====
// Controller of the ordered task dispatch queue: handshake sequencing.
// Depends on otdq_pkg.
`timescale 1ns / 1ps
module otdq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output otdq_pkg::dp_cmd_t    cmd_o,
  input  otdq_pkg::dp_status_t sts_i
);
  import otdq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_OUT} state_e;
  state_e state_q;
  logic   out_valid_q;

  // The result register may be refilled when it is empty or being taken.
  logic take;
  assign take       = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o.load    = take;
  assign cmd_o.execute = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_EXEC) && cmd_o.execute && sts_i.done) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (take) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (cmd_o.execute && sts_i.done) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end
endmodule

// ===== hdl/otdq_dp.sv =====
// Datapath of the ordered task dispatch queue: sorted shift queue, counters,
// run state and configuration. Depends on otdq_pkg.
`timescale 1ns / 1ps
module otdq_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [7:0]           cfg_data_i,
  input  otdq_pkg::in_beat_t   in_i,
  output otdq_pkg::out_beat_t  out_o,
  input  otdq_pkg::dp_cmd_t    cmd_i,
  output otdq_pkg::dp_status_t sts_o
);
  import otdq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [31:0] ids_q   [QUEUE_DEPTH];
  logic [7:0]  prios_q [QUEUE_DEPTH];
  logic [23:0] sizes_q [QUEUE_DEPTH];
  logic [15:0] tags_q  [QUEUE_DEPTH];
  logic [CW-1:0] count_q;
  mode_e       mode_q;
  logic [31:0] next_id_q, sub_q, fin_q;
  logic [7:0]  run_q, max_run_q;
  logic [1:0]  policy_q;
  in_beat_t    beat_q;
  out_beat_t   out_q;

  // Per-slot flags captured in the load cycle.
  logic [QUEUE_DEPTH-1:0] ins_d, ins_q, hit_d, hit_q;

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      logic valid, ahead;
      valid = (CW'(i) < count_q);
      ahead = 1'b0;
      if (policy_q == POLICY_PRIORITY) begin
        ahead = in_i.task_priority > prios_q[i];
      end else if (policy_q == POLICY_SHORTEST) begin
        ahead = in_i.job_size < sizes_q[i];
      end
      ins_d[i] = valid && ahead;
      hit_d[i] = valid && (ids_q[i] == in_i.target_id) && (in_i.target_id != '0);
    end
  end

  // First set flag marks the insert point or the match nearest the head.
  logic [QUEUE_DEPTH-1:0] ins_first, hit_first, ins_after, hit_after;
  always_comb begin
    logic si, sh;
    si = 1'b0;
    sh = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ins_first[i] = ins_q[i] && !si;
      hit_first[i] = hit_q[i] && !sh;
      ins_after[i] = si;
      hit_after[i] = sh;
      si = si | ins_q[i];
      sh = sh | hit_q[i];
    end
  end

  logic [IW-1:0] hit_pos;
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (hit_first[i]) begin
        hit_pos = IW'(i);
      end
    end
  end

  logic any_ins, any_hit, full, sub_ok, disp_ok;
  assign any_ins = |ins_q;
  assign any_hit = |hit_q;
  assign full    = (count_q == CW'(QUEUE_DEPTH));
  assign sub_ok  = (beat_q.action == ACT_SUBMIT) && beat_q.can_schedule &&
                   (mode_q == MODE_RUNNING) && !full;
  assign disp_ok = (beat_q.action == ACT_DISPATCH) && (mode_q == MODE_RUNNING) &&
                   (run_q < max_run_q) && (count_q != '0);

  assign sts_o.done = 1'b1;
  assign out_o      = out_q;

  logic [31:0] nid;
  assign nid = (next_id_q == 32'hFFFF_FFFF) ? 32'd1 : next_id_q + 32'd1;

  // Queue storage: shift right on insert, shift left on removal.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      beat_q <= in_i;
      ins_q  <= ins_d;
      hit_q  <= hit_d;
    end
    if (cmd_i.execute) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (sub_ok) begin
          if ((any_ins && ins_first[i]) || (!any_ins && count_q[IW-1:0] == IW'(i))) begin
            ids_q[i]   <= next_id_q;
            prios_q[i] <= beat_q.task_priority;
            sizes_q[i] <= beat_q.job_size;
            tags_q[i]  <= beat_q.task_tag;
          end else if (any_ins && ins_after[i] && i > 0) begin
            ids_q[i]   <= ids_q[(i > 0) ? i - 1 : 0];
            prios_q[i] <= prios_q[(i > 0) ? i - 1 : 0];
            sizes_q[i] <= sizes_q[(i > 0) ? i - 1 : 0];
            tags_q[i]  <= tags_q[(i > 0) ? i - 1 : 0];
          end
        end else if (disp_ok || ((beat_q.action == ACT_CANCEL) && any_hit)) begin
          if (i < QUEUE_DEPTH - 1 && (disp_ok || hit_first[i] || hit_after[i])) begin
            ids_q[i]   <= ids_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            prios_q[i] <= prios_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            sizes_q[i] <= sizes_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            tags_q[i]  <= tags_q[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      mode_q    <= MODE_STOPPED;
      next_id_q <= 32'd1;
      run_q     <= '0;
      sub_q     <= '0;
      fin_q     <= '0;
      policy_q  <= POLICY_PRIORITY;
      max_run_q <= MAX_RUN_RESET;
      out_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_POLICY) begin
          policy_q <= cfg_data_i[1:0];
        end else begin
          max_run_q <= cfg_data_i;
        end
      end
      if (cmd_i.execute) begin
        logic [2:0]    st;
        logic [31:0]   rid;
        logic [15:0]   rtag;
        logic [CW-1:0] cnt;
        logic [7:0]    run;
        mode_e         md;
        logic [31:0]   sub, fin;
        st   = ST_OK;
        rid  = '0;
        rtag = '0;
        cnt  = count_q;
        run  = run_q;
        md   = mode_q;
        sub  = sub_q;
        fin  = fin_q;
        case (beat_q.action)
          ACT_SUBMIT: begin
            if (!beat_q.can_schedule) begin
              st = ST_UNSCHEDULABLE;
            end else if (mode_q != MODE_RUNNING) begin
              st = ST_NOT_RUNNING;
            end else if (full) begin
              st = ST_FULL;
            end else begin
              rid = next_id_q;
              next_id_q <= nid;
              cnt = count_q + CW'(1);
              sub = sub_q + 32'd1;
            end
          end
          ACT_CANCEL: begin
            if (any_hit) begin
              rid  = ids_q[hit_pos];
              rtag = tags_q[hit_pos];
              cnt  = count_q - CW'(1);
            end else begin
              st = ST_NOT_FOUND;
            end
          end
          ACT_DISPATCH: begin
            if (mode_q != MODE_RUNNING) begin
              st = ST_NOT_RUNNING;
            end else if (run_q >= max_run_q) begin
              st = ST_AT_LIMIT;
            end else if (count_q == '0) begin
              st = ST_EMPTY;
            end else begin
              rid  = ids_q[0];
              rtag = tags_q[0];
              cnt  = count_q - CW'(1);
              run  = run_q + 8'd1;
            end
          end
          ACT_COMPLETE: begin
            if (run_q != '0) begin
              run = run_q - 8'd1;
              fin = fin_q + 32'd1;
            end
          end
          ACT_START: begin
            if (mode_q == MODE_STOPPED) begin
              md = MODE_RUNNING;
            end
          end
          ACT_STOP: begin
            md = MODE_STOPPED;
          end
          ACT_PAUSE: begin
            if (mode_q == MODE_RUNNING) begin
              md = MODE_PAUSED;
            end
          end
          default: begin
            if (mode_q == MODE_PAUSED) begin
              md = MODE_RUNNING;
            end
          end
        endcase
        count_q <= cnt;
        run_q   <= run;
        mode_q  <= md;
        sub_q   <= sub;
        fin_q   <= fin;
        out_q.status          <= st;
        out_q.result_id       <= rid;
        out_q.result_tag      <= rtag;
        out_q.queue_level     <= 5'(cnt);
        out_q.running_count   <= run;
        out_q.run_mode        <= md;
        out_q.scheduled_total <= sub;
        out_q.completed_total <= fin;
      end
    end
  end
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the ordered task dispatch queue: a scheduler
// predictor in a small scoreboard class, with tasks that drive the block.
// Depends on otdq_pkg and ordered_task_dispatch_queue.
`timescale 1ns / 1ps
module tb_top;
  import otdq_pkg::*;

  localparam int QDEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;

  // Scoreboard: keeps its own copy of the scheduler state, predicts one result
  // beat per accepted input beat and compares results in order.
  class sched_board;
    logic [31:0] q_id[$];
    logic [7:0]  q_prio[$];
    logic [23:0] q_size[$];
    logic [15:0] q_tag[$];
    mode_e       mode;
    logic [31:0] issue_id;
    logic [7:0]  running;
    logic [31:0] submitted;
    logic [31:0] finished;
    logic [1:0]  policy;
    logic [7:0]  run_limit;
    out_beat_t   pending[$];
    int          mismatches;

    function new();
      mode = MODE_STOPPED; issue_id = 1; running = 0;
      submitted = 0; finished = 0; policy = 0; run_limit = MAX_RUN_RESET;
      mismatches = 0;
    endfunction

    function void drop(int pos);
      q_id.delete(pos); q_prio.delete(pos); q_size.delete(pos); q_tag.delete(pos);
    endfunction

    function void note_action(in_beat_t b);
      out_beat_t r;
      int pos;
      bit ahead;
      r = '0;
      r.status = ST_OK;
      case (action_e'(b.action))
        ACT_SUBMIT: begin
          if (!b.can_schedule) r.status = ST_UNSCHEDULABLE;
          else if (mode != MODE_RUNNING) r.status = ST_NOT_RUNNING;
          else if (q_id.size() >= QDEPTH) r.status = ST_FULL;
          else begin
            r.result_id = issue_id;
            issue_id = issue_id + 1;
            if (issue_id == 0) issue_id = 1;
            // Equal ranks go behind existing entries; unused policies append.
            pos = q_id.size();
            for (int i = 0; i < q_id.size(); i++) begin
              ahead = 0;
              if (policy == POLICY_PRIORITY) ahead = b.task_priority > q_prio[i];
              else if (policy == POLICY_SHORTEST) ahead = b.job_size < q_size[i];
              if (ahead) begin
                pos = i;
                break;
              end
            end
            q_id.insert(pos, r.result_id); q_prio.insert(pos, b.task_priority);
            q_size.insert(pos, b.job_size); q_tag.insert(pos, b.task_tag);
            submitted++;
          end
        end
        ACT_CANCEL: begin
          r.status = ST_NOT_FOUND;
          if (b.target_id != 0) begin
            for (int i = 0; i < q_id.size(); i++) begin
              if (q_id[i] == b.target_id) begin
                r.result_id = q_id[i]; r.result_tag = q_tag[i];
                drop(i);
                r.status = ST_OK;
                break;
              end
            end
          end
        end
        ACT_DISPATCH: begin
          if (mode != MODE_RUNNING) r.status = ST_NOT_RUNNING;
          else if (running >= run_limit) r.status = ST_AT_LIMIT;
          else if (q_id.size() == 0) r.status = ST_EMPTY;
          else begin
            r.result_id = q_id[0]; r.result_tag = q_tag[0];
            drop(0);
            running++;
          end
        end
        ACT_COMPLETE: if (running > 0) begin
          running--;
          finished++;
        end
        ACT_START:  if (mode == MODE_STOPPED) mode = MODE_RUNNING;
        ACT_STOP:   mode = MODE_STOPPED;
        ACT_PAUSE:  if (mode == MODE_RUNNING) mode = MODE_PAUSED;
        default:    if (mode == MODE_PAUSED) mode = MODE_RUNNING;
      endcase
      r.queue_level = 5'(q_id.size());
      r.running_count = running;
      r.run_mode = mode;
      r.scheduled_total = submitted;
      r.completed_total = finished;
      pending.push_back(r);
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t exp_r;
      bit bad;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %p", got);
        return;
      end
      exp_r = pending.pop_front();
      bad = got.status !== exp_r.status || got.result_id !== exp_r.result_id ||
            got.result_tag !== exp_r.result_tag ||
            got.queue_level !== exp_r.queue_level ||
            got.running_count !== exp_r.running_count ||
            got.run_mode !== exp_r.run_mode ||
            got.scheduled_total !== exp_r.scheduled_total ||
            got.completed_total !== exp_r.completed_total;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) $display("Mismatch: expected %p, got %p", exp_r, got);
      end
    endfunction
  endclass

  logic      clk, rst_n;
  logic      cfg_we, cfg_idx;
  logic [7:0] cfg_data;
  logic      in_valid, in_stall, out_valid, out_stall;
  in_beat_t  in_data;
  out_beat_t out_data;

  sched_board board;
  int send_idle_pct, recv_idle_pct;
  bit hold_off;  // long receiver stall requested by the stimulus
  int cycles;

  ordered_task_dispatch_queue dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_data_i(in_data), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_data_o(out_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Result side: random stall, plus a long hold-off when asked for. A beat is
  // taken at an edge where valid is high and our stall is low.
  initial begin
    int hold;
    out_stall = 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_result(out_data);
      if (hold_off && hold == 0) hold = 300;
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Offer one beat, with an optional random gap first, and wait until taken.
  // Valid stays high after the beat is taken until the next gap or drain.
  task automatic send_beat(in_beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    board.note_action(b);
  endtask

  // Block until every predicted result has come, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] value);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POLICY) board.policy = value[1:0];
    else board.run_limit = value;
    @(posedge clk);
  endtask

  function automatic in_beat_t make_beat(action_e act);
    in_beat_t b;
    b = '0;
    b.action = act;
    return b;
  endfunction

  function automatic in_beat_t make_submit(logic [7:0] prio, logic [23:0] size);
    in_beat_t b;
    b = make_beat(ACT_SUBMIT);
    b.task_tag = 16'($urandom);
    b.task_priority = prio;
    b.job_size = size;
    b.can_schedule = 1'b1;
    b.target_id = $urandom;
    return b;
  endfunction

  // Random beat, weighted towards well-formed traffic in the running state.
  function automatic in_beat_t random_beat();
    in_beat_t b;
    int pick;
    int n;
    pick = $urandom_range(99);
    b = make_submit(8'($urandom), 24'($urandom));
    if (pick < 8) b.task_priority = 8'($urandom_range(3));
    if (pick < 4) b.job_size = 24'($urandom_range(3));
    if (pick < 40) begin
      b.can_schedule = ($urandom_range(15) != 0);
    end else if (pick < 55) begin
      b.action = ACT_CANCEL;
      n = board.q_id.size();
      if (n > 0 && $urandom_range(3) != 0) b.target_id = board.q_id[$urandom_range(n - 1)];
      else if ($urandom_range(1)) b.target_id = 0;
    end else if (pick < 75) b.action = ACT_DISPATCH;
    else if (pick < 88) b.action = ACT_COMPLETE;
    else if (board.mode != MODE_RUNNING && pick < 94) begin
      b.action = (board.mode == MODE_PAUSED) ? ACT_RESUME : ACT_START;
    end else b.action = 3'($urandom_range(4, 7));
    return b;
  endfunction

  initial begin
    in_beat_t b;
    board = new();
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = 1'b0; cfg_data = '0;
    in_valid = 1'b0; in_data = '0;
    hold_off = 1'b0;
    send_idle_pct = 13; recv_idle_pct = 87;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset-time rejects, run control and every status code but the at-limit one.
    b = make_submit(8'hff, 24'hffffff); b.can_schedule = 1'b0; send_beat(b);
    send_beat(make_submit(8'h00, 24'h0));              // not running
    send_beat(make_beat(ACT_DISPATCH));               // not running
    send_beat(make_beat(ACT_COMPLETE));               // nothing running
    send_beat(make_beat(ACT_RESUME));
    send_beat(make_beat(ACT_START));
    send_beat(make_beat(ACT_DISPATCH));               // empty
    send_beat(make_submit(8'h00, 24'hffffff));
    send_beat(make_submit(8'hff, 24'h000000));
    send_beat(make_submit(8'hff, 24'h000001));        // ties go behind
    b = make_beat(ACT_CANCEL); b.target_id = 0; send_beat(b);
    b = make_beat(ACT_CANCEL); b.target_id = 32'hffffffff; send_beat(b);
    b = make_beat(ACT_CANCEL); b.target_id = 2; send_beat(b);
    send_beat(make_beat(ACT_PAUSE));
    send_beat(make_submit(8'h10, 24'h10));            // paused: not running
    send_beat(make_beat(ACT_DISPATCH));
    b = make_beat(ACT_CANCEL); b.target_id = 1; send_beat(b);
    send_beat(make_beat(ACT_RESUME));
    send_beat(make_beat(ACT_DISPATCH));
    send_beat(make_beat(ACT_COMPLETE));
    send_beat(make_beat(ACT_STOP));
    send_beat(make_beat(ACT_START));
    for (int i = 0; i < QDEPTH + 1; i++) send_beat(make_submit(8'($urandom), 24'($urandom)));
    drain();

    // At-limit case with the limit set to one.
    write_reg(CFG_MAX_RUN, 8'd1);
    repeat (3) send_beat(make_beat(ACT_DISPATCH));
    drain();

    // Random phases across policies and limits, including the unused policies
    // and a zero limit. A long output hold-off fills the block once.
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CFG_POLICY, 8'(phase % 4));
      write_reg(CFG_MAX_RUN, (phase == 3) ? 8'd0 : (phase == 4) ? 8'd255 :
                8'($urandom_range(1, 12)));
      if (phase == 2) begin
        send_idle_pct = 87; recv_idle_pct = 13;
      end else if (phase == 4) begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      if (phase == 5) begin
        // Raised and lowered again so the result side sees the request exactly once.
        hold_off = 1'b1;
        repeat (2) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 80; i++) begin
        send_beat(random_beat());
      end
      drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
